// File: rtl/core/teq_pkg.sv
package teq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] event_time;
		logic [3:0]  relay_id;
		logic        relay_on;
	} cmd_t;

	typedef struct packed {
		logic       fire_valid;
		logic [3:0] fire_relay;
		logic       fire_state;
		logic       insert_rejected;
		logic       relay_pending;
		logic       queue_nonempty;
		logic [4:0] queue_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] due_time;
		logic [3:0]  relay;
		logic        state;
	} entry_t;

endpackage

// File: rtl/core/teq_cmd_if.sv
interface teq_cmd_if;
	import teq_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/teq_rsp_if.sv
interface teq_rsp_if;
	import teq_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/timed_event_queue.sv
// Timed event queue: a sorted list of timed relay actions, earliest due first.
// Channel cmd carries one beat per operation: schedule (insert an entry with a
// due time, relay and state), tick (fire the head entry if it is due strictly
// before the given time) or query (is any pending entry for a relay). Channel
// rsp returns exactly one beat per cmd beat with the fire data, the reject
// and query flags and the number of entries left.
// Entries live in a single-port-write, single-port-read memory; one shared
// magnitude comparator and a small sequencer walk the memory one entry per
// cycle. A schedule walks the entries due later than the new one, a tick
// that fires shifts the remaining entries down, and a query reads entries
// until it finds the relay or reaches the tail. cmd is not ready again until
// the rsp beat has been taken, so one operation is in flight.
// When the receiver stalls, the response is held stable in its register and
// cmd stays not ready. Reset empties the queue; memory contents are left as
// they are and are never used before they are written.
module timed_event_queue (
	input  logic      clk,
	input  logic      arst_n,
	teq_cmd_if.sink   cmd,
	teq_rsp_if.source rsp
);
	import teq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_INSERT    = 6'b000010,
		S_POP_HEAD  = 6'b000100,
		S_POP_SHIFT = 6'b001000,
		S_QUERY     = 6'b010000,
		S_DONE      = 6'b100000
	} state_t;

	state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [31:0] time_q;
	logic [3:0]  relay_q;
	logic        on_q;
	rsp_t        res_q, res_d;

	entry_t      entry_mem [QUEUE_DEPTH];
	entry_t      rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic        we;
	logic [IDX_W-1:0] wr_addr;
	entry_t      wr_data;

	logic [31:0] cmp_a, cmp_b;
	logic        a_lt_b;
	logic        accept;
	entry_t      new_entry;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign new_entry = '{due_time: time_q, relay: relay_q, state: on_q};

	// The one comparator: insert asks whether the new time is before the
	// stored one, pop asks whether the stored time is before the tick time.
	always_comb begin
		if (state_q == S_INSERT) begin
			cmp_a = time_q;
			cmp_b = rd_q.due_time;
		end else begin
			cmp_a = rd_q.due_time;
			cmp_b = time_q;
		end
	end
	assign a_lt_b = cmp_a < cmp_b;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		k_d     = k_q;
		res_d   = res_q;
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = k_q[IDX_W-1:0];
		wr_data = rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					res_d = '0;
					unique case (cmd.data.opcode)
						OP_SCHEDULE: begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								res_d.insert_rejected = 1'b1;
								state_d = S_DONE;
							end else begin
								k_d     = count_q;
								rd_addr = IDX_W'(count_q - CNT_W'(1));
								state_d = S_INSERT;
							end
						end
						OP_TICK: begin
							state_d = (count_q == '0) ? S_DONE : S_POP_HEAD;
						end
						OP_QUERY: begin
							k_d     = '0;
							state_d = (count_q == '0) ? S_DONE : S_QUERY;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_INSERT: begin
				we = 1'b1;
				// Walk down from the tail, moving later entries up by one.
				if (k_q == '0 || !a_lt_b) begin
					wr_data = new_entry;
					count_d = count_q + CNT_W'(1);
					state_d = S_DONE;
				end else begin
					k_d     = k_q - CNT_W'(1);
					rd_addr = IDX_W'(k_q - CNT_W'(2));
				end
			end
			S_POP_HEAD: begin
				if (a_lt_b) begin
					res_d.fire_valid = 1'b1;
					res_d.fire_relay = rd_q.relay;
					res_d.fire_state = rd_q.state;
					count_d = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						state_d = S_DONE;
					end else begin
						k_d     = CNT_W'(1);
						rd_addr = IDX_W'(1);
						state_d = S_POP_SHIFT;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP_SHIFT: begin
				// count_q already holds the reduced count here.
				we      = 1'b1;
				wr_addr = IDX_W'(k_q - CNT_W'(1));
				if (k_q == count_q) begin
					state_d = S_DONE;
				end else begin
					k_d     = k_q + CNT_W'(1);
					rd_addr = IDX_W'(k_q + CNT_W'(1));
				end
			end
			S_QUERY: begin
				if (rd_q.relay == relay_q) begin
					res_d.relay_pending = 1'b1;
					state_d = S_DONE;
				end else if (k_q + CNT_W'(1) == count_q) begin
					state_d = S_DONE;
				end else begin
					k_d     = k_q + CNT_W'(1);
					rd_addr = IDX_W'(k_q + CNT_W'(1));
				end
			end
			S_DONE: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			res_q   <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// A due time of zero is stored as one.
			if (cmd.data.opcode == OP_SCHEDULE && cmd.data.event_time == '0) begin
				time_q <= 32'd1;
			end else begin
				time_q <= cmd.data.event_time;
			end
			relay_q <= cmd.data.relay_id;
			on_q    <= cmd.data.relay_on;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rd_q <= entry_mem[rd_addr];
	end

	always_comb begin
		rsp.data                = res_q;
		rsp.data.queue_nonempty = (count_q != '0);
		rsp.data.queue_count    = 5'(count_q);
	end
	assign rsp.valid = (state_q == S_DONE);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("pending count exceeds queue depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !cmd.ready)
		else $error("command accepted while a response is outstanding");

	a_reject_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.insert_rejected) |->
		(count_q == CNT_W'(QUEUE_DEPTH) && !rsp.data.fire_valid))
		else $error("insert rejected while queue has room");

	a_fire_drops_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_HEAD && a_lt_b) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("fired entry did not reduce the pending count");
`endif

endmodule
